>>> hw/rtl/text_console_writer_assert.svh
// Assertion macros used by the text console writer back end.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define TCW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> hw/rtl/tcw_pkg.sv
// Types, constants and helpers for the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int LAST_ROW_START = CELLS - COLUMNS;
  localparam int ADDR_W         = $clog2(CELLS);
  localparam int COL_W          = 7;
  localparam int ROW_W          = 5;
  localparam int CHAR_W         = 8;
  localparam int DATA_W         = 16;
  localparam int OP_W           = 2;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_SET,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] character;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } rsp_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  // Linear cell address: row * COLUMNS + col (constant multiply).
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tcw_front.sv
// Front end: accepts transactions, saturates coordinates, classifies into commands.
`default_nettype none
module tcw_front (
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tcw_pkg::req_t in_data_i,
  input  wire logic          accept_en_i,
  input  wire logic          q_ready_i,
  output logic               push_o,
  output tcw_pkg::cmd_t      cmd_o
);
  import tcw_pkg::*;

  logic [COL_W-1:0] col_sat;
  logic [ROW_W-1:0] row_sat;

  assign in_ready_o = q_ready_i && accept_en_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign col_sat = (in_data_i.column > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                            : in_data_i.column;
  assign row_sat = (in_data_i.row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                      : in_data_i.row;

  always_comb begin
    cmd_o.ch   = in_data_i.character;
    cmd_o.col  = col_sat;
    cmd_o.row  = row_sat;
    cmd_o.addr = cell_addr(row_sat, col_sat);
    case (in_data_i.opcode)
      OP_PUT:  cmd_o.kind = (in_data_i.character == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_PUT;
      OP_SET:  cmd_o.kind = CMD_SET;
      OP_READ: cmd_o.kind = CMD_READ;
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/tcw_queue.sv
// Short command queue between front and back end.
`default_nettype none
module tcw_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tcw_pkg::cmd_t cmd_i,
  output logic               ready_o,
  output logic               valid_o,
  output tcw_pkg::cmd_t      cmd_o,
  input  wire logic          pop_i
);
  import tcw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tcw_back.sv
// Back end: cursor, screen store sequencing (clear, put, read, scroll), result register.
`default_nettype none
`include "text_console_writer_assert.svh"
module tcw_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire tcw_pkg::cmd_t q_cmd_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tcw_pkg::rsp_t      out_data_o
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RD_WAIT = 3'd2;
  localparam logic [2:0] ST_PUT_WR  = 3'd3;
  localparam logic [2:0] ST_SCROLL  = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(LAST_ROW_START);

  typedef struct packed {
    logic             scroll;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } adv_t;

  function automatic adv_t advance(input logic [COL_W-1:0] col,
                                   input logic [ROW_W-1:0] row,
                                   input logic nl);
    adv_t a;
    a.scroll = 1'b0;
    if (nl) begin
      a.col = '0;
      a.row = row + 1'b1;
    end else begin
      a.col = col + 1'b1;
      a.row = row;
    end
    if (a.col == COL_W'(COLUMNS)) begin
      a.col = '0;
      a.row = a.row + 1'b1;
    end
    if (a.row == ROW_W'(ROWS)) begin
      a.scroll = 1'b1;
      a.col    = '0;
      a.row    = ROW_W'(ROWS - 1);
    end
    return a;
  endfunction

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic              rd_act_q, rd_act_d;
  logic              wb_q, wb_d;
  logic              wb_last_q, wb_last_d;
  logic [ADDR_W-1:0] wb_addr_q, wb_addr_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_wa, ram_ra;
  logic [DATA_W-1:0] ram_wd, ram_rd;
  logic [ADDR_W-1:0] cur_addr;
  adv_t              adv;
  logic              do_adv;

  tcw_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .re_i    (ram_re),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  assign cur_addr    = cell_addr(cur_row_q, cur_col_q);
  // Newline advance when dispatched from idle; plain advance after a put write.
  assign adv         = advance(cur_col_q, cur_row_q, state_q != ST_PUT_WR);
  assign pop_o       = (state_q == ST_IDLE) && q_valid_i && !out_valid_q;
  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    ch_d        = ch_q;
    rd_act_d    = rd_act_q;
    wb_d        = 1'b0;
    wb_last_d   = wb_last_q;
    wb_addr_d   = wb_addr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_wa      = '0;
    ram_wd      = '0;
    ram_re      = 1'b0;
    ram_ra      = '0;
    do_adv      = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = idx_q;
        if (idx_q == LAST_ADDR) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          case (q_cmd_i.kind)
            CMD_SET: begin
              cur_col_d   = q_cmd_i.col;
              cur_row_d   = q_cmd_i.row;
              out_d       = '{cell_data: '0, cursor_col: q_cmd_i.col,
                              cursor_row: q_cmd_i.row};
              out_valid_d = 1'b1;
            end
            CMD_READ: begin
              ram_re  = 1'b1;
              ram_ra  = q_cmd_i.addr;
              state_d = ST_RD_WAIT;
            end
            CMD_PUT: begin
              ram_re  = 1'b1;
              ram_ra  = cur_addr;
              ch_d    = q_cmd_i.ch;
              state_d = ST_PUT_WR;
            end
            CMD_NEWLINE: begin
              do_adv = 1'b1;
            end
            default: begin
              out_d       = '{cell_data: '0, cursor_col: cur_col_q, cursor_row: cur_row_q};
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        out_d       = '{cell_data: ram_rd, cursor_col: cur_col_q, cursor_row: cur_row_q};
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_PUT_WR: begin
        // Keep the attribute byte, replace the character byte.
        ram_we = 1'b1;
        ram_wa = cur_addr;
        ram_wd = {ram_rd[DATA_W-1:CHAR_W], ch_q};
        do_adv = 1'b1;
      end
      ST_SCROLL: begin
        // Read cell idx+COLUMNS (or idx itself on the last row), write idx in the following cycle.
        if (rd_act_q) begin
          ram_re    = 1'b1;
          ram_ra    = (idx_q < LAST_ROW) ? idx_q + ADDR_W'(COLUMNS) : idx_q;
          wb_d      = 1'b1;
          wb_addr_d = idx_q;
          wb_last_d = (idx_q >= LAST_ROW);
          if (idx_q == LAST_ADDR) begin
            rd_act_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (wb_q) begin
          ram_we = 1'b1;
          ram_wa = wb_addr_q;
          ram_wd = wb_last_q ? {ram_rd[DATA_W-1:CHAR_W], BLANK_CHAR} : ram_rd;
        end
        if (!rd_act_q && wb_q) begin
          idx_d       = '0;
          out_d       = '{cell_data: '0, cursor_col: cur_col_q, cursor_row: cur_row_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_adv) begin
      cur_col_d = adv.col;
      cur_row_d = adv.row;
      if (adv.scroll) begin
        idx_d    = '0;
        rd_act_d = 1'b1;
        state_d  = ST_SCROLL;
      end else begin
        out_d       = '{cell_data: '0, cursor_col: adv.col, cursor_row: adv.row};
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      rd_act_q    <= 1'b0;
      wb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      rd_act_q    <= rd_act_d;
      wb_q        <= wb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    wb_last_q <= wb_last_d;
    wb_addr_q <= wb_addr_d;
    out_q     <= out_d;
  end

  `TCW_ASSERT(a_cursor_in_range, (cur_col_q < COL_W'(COLUMNS)) && (cur_row_q < ROW_W'(ROWS)), "cursor out of range")
  `TCW_NEVER(a_pop_over_result, pop_o && out_valid_q, "command popped while result pending")
  `TCW_NEVER(a_ram_same_addr, ram_we && ram_re && (ram_wa == ram_ra), "read and write to same cell")
  `TCW_NEVER(a_pop_while_clearing, clearing_o && pop_o, "command popped during clearing pass")

endmodule
`default_nettype wire

>>> hw/rtl/text_console_writer.sv
// Top level of the text console writer: front end, command queue, back end.
// Path, accept to result valid: the queue registers the command, the back end pops it in idle
//   and loads the result register; read cell and put character first read the screen RAM.
// A put or newline that scrolls adds a pass over the screen. One command runs at a time,
//   paced by the result register and the read-then-write sequence on the single screen RAM.
// Reset: cursor to 0,0; a clearing pass zeroes all 2000 cells, one per cycle, in_ready_o low.
`default_nettype none
module text_console_writer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tcw_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tcw_pkg::rsp_t      out_data_o
);
  import tcw_pkg::*;

  // Front-to-queue transaction.
  logic push;
  cmd_t push_cmd;
  logic q_ready;

  // Queue-to-back transaction.
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // Held high by the back end while the screen store is being zeroed.
  logic clearing;

  // Front end: saturates coordinates, resolves newline, precomputes the read address.
  tcw_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .accept_en_i (!clearing),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Two-entry queue lets the front keep accepting while the back end works or stalls.
  tcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  // Back end: owns the cursor, the screen RAM and the result register.
  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> dv/tb_text_console_writer.sv
// Testbench for text_console_writer: directed and random console traffic checked by a screen tracker.
module tb_text_console_writer;
  import tcw_pkg::*;

  // Opcode 3 is not defined by the block; it must leave everything untouched.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int ITEM_TARGET = 1250;
  localparam int MAX_WAIT    = 17;
  localparam int DRAIN_WAIT  = 30;
  // Clearing pass + ~1300 transactions at worst-case gaps and stalls
  // + a few hundred scrolls, each a pass over the screen, with margin on top.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Shadow of the screen and cursor. Expected replies are queued per accepted
  // transaction and popped in order as the block delivers them.
  class screen_tracker;
    logic [DATA_W-1:0] shadow_cells [CELLS];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    rsp_t              pending_replies [$];
    int                mismatches;
    int                replies_checked;
    int                scrolls;
    int                wraps;
    int                reads;

    function new();
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      cur_col = '0;
      cur_row = '0;
      mismatches = 0;
      replies_checked = 0;
      scrolls = 0;
      wraps = 0;
      reads = 0;
    endfunction

    function void note_transaction(req_t t);
      rsp_t             want;
      logic [COL_W-1:0] sat_col;
      logic [ROW_W-1:0] sat_row;
      want    = '0;
      sat_col = (t.column > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : t.column;
      sat_row = (t.row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : t.row;
      case (t.opcode)
        OP_PUT: begin
          if (t.character == NEWLINE_CHAR) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
          end else begin
            // Character byte only; the attribute byte stays.
            shadow_cells[int'(cur_row) * COLUMNS + int'(cur_col)][CHAR_W-1:0] = t.character;
            cur_col = cur_col + 1'b1;
          end
          if (cur_col >= COL_W'(COLUMNS)) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
            wraps++;
          end
          if (cur_row >= ROW_W'(ROWS)) begin
            // Scroll up one row; the new last row gets blanks, attributes kept.
            for (int i = 0; i < LAST_ROW_START; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
            for (int i = LAST_ROW_START; i < CELLS; i++)
              shadow_cells[i] = {shadow_cells[i][DATA_W-1:CHAR_W], BLANK_CHAR};
            cur_col = '0;
            cur_row = ROW_W'(ROWS - 1);
            scrolls++;
          end
        end
        OP_SET: begin
          cur_col = sat_col;
          cur_row = sat_row;
        end
        OP_READ: begin
          want.cell_data = shadow_cells[int'(sat_row) * COLUMNS + int'(sat_col)];
          reads++;
        end
        default: ;
      endcase
      want.cursor_col = cur_col;
      want.cursor_row = cur_row;
      pending_replies.push_back(want);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("reply with nothing outstanding: %h", got));
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (got.cell_data !== want.cell_data)
        flag_mismatch($sformatf("cell_data got %h want %h", got.cell_data, want.cell_data));
      if (got.cursor_col !== want.cursor_col)
        flag_mismatch($sformatf("cursor_col got %0d want %0d", got.cursor_col, want.cursor_col));
      if (got.cursor_row !== want.cursor_row)
        flag_mismatch($sformatf("cursor_row got %0d want %0d", got.cursor_row, want.cursor_row));
    endtask
  endclass

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  req_t     in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  rsp_t     out_data_o;
  // Quiet flags: bit 0 silences sender gaps, bit 1 silences receiver stalls.
  bit [1:0] quiet     = '0;
  int       cycles    = 0;
  int       sent      = 0;
  int       counted   = 0;

  screen_tracker tracker = new();

  text_console_writer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run-away guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles,
               tracker.pending_replies.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Alternate between stretches with random gaps and stretches at full rate.
  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk_i);
      quiet <= {($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0)};
    end
  end

  function automatic int draw_wait(bit no_gap);
    return no_gap ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic req_t make_req(logic [OP_W-1:0] op, int ch, int col, int row);
    req_t t;
    t.opcode    = op;
    t.character = CHAR_W'(ch);
    t.column    = COL_W'(col);
    t.row       = ROW_W'(row);
    return t;
  endfunction

  // One transaction on the request channel. Valid is only lowered when a gap
  // follows, so back-to-back transactions keep it high across the edge.
  task automatic send(req_t t);
    int gap;
    gap = draw_wait(quiet[0]);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_transaction(t);
    sent++;
    if (t.opcode != OP_UNUSED) counted++;
  endtask

  // Reply channel: random stall before each transaction, then wait for it.
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_wait(quiet[1]);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      tracker.check_result(out_data_o);
    end
  end

  initial begin
    int pick;
    int n;
    int c;
    int r;
    int ch;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    send(make_req(OP_READ, 0, 0, 0));              // cleared store reads zero
    send(make_req(OP_PUT, 8'h41, 0, 0));
    send(make_req(OP_PUT, 8'h00, 0, 0));           // character byte extremes
    send(make_req(OP_PUT, 8'hFF, 0, 0));
    send(make_req(OP_READ, 0, 0, 0));
    send(make_req(OP_READ, 0, 1, 0));
    send(make_req(OP_READ, 0, 2, 0));
    send(make_req(OP_SET, 0, 127, 31));            // both coordinates saturate
    send(make_req(OP_READ, 8'hFF, 127, 31));       // saturated read of last cell
    send(make_req(OP_PUT, 8'h78, 0, 0));           // wrap off the last row: scroll
    send(make_req(OP_READ, 0, 79, 23));            // scrolled-up character
    send(make_req(OP_READ, 0, 0, 24));             // blanked last row
    send(make_req(OP_PUT, NEWLINE_CHAR, 0, 0));    // newline on last row scrolls too
    send(make_req(OP_SET, 0, 100, 3));             // column saturates only
    send(make_req(OP_SET, 0, 3, 30));              // row saturates only
    send(make_req(OP_SET, 0, 0, 0));
    send(make_req(OP_PUT, NEWLINE_CHAR, 0, 0));    // plain newline
    send(make_req(OP_SET, 0, 79, 5));
    send(make_req(OP_PUT, 8'h7A, 0, 0));           // wrap without scroll
    send(make_req(OP_READ, 0, 79, 5));
    send(make_req(OP_UNUSED, 8'hFF, 127, 31));     // unused opcode: no change
    send(make_req(OP_UNUSED, 0, 0, 0));
    send(make_req(OP_READ, 0, 0, 6));

    // ---- random part ----
    while (counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // Text run: place the cursor, type a few characters, read some back.
        // Last row and line ends are favored so wraps and scrolls happen.
        r = ($urandom_range(0, 7) == 0) ? ROWS - 1 : $urandom_range(0, ROWS - 1);
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(COLUMNS - 10, COLUMNS - 1)
                                        : $urandom_range(0, COLUMNS - 1);
        send(make_req(OP_SET, $urandom, c, r));
        n = $urandom_range(1, 12);
        repeat (n) begin
          ch = ($urandom_range(0, 9) == 0) ? NEWLINE_CHAR : $urandom_range(0, 255);
          send(make_req(OP_PUT, ch, $urandom, $urandom));
        end
        repeat ($urandom_range(1, 3)) begin
          send(make_req(OP_READ, $urandom, c + $urandom_range(0, n),
                        ($urandom_range(0, 3) == 0 && r > 0) ? r - 1 : r));
        end
      end else if (pick < 75) begin
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, COLUMNS - 1);
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, ROWS - 1);
        send(make_req(OP_READ, $urandom, c, r));
      end else if (pick < 90) begin
        send(make_req(OP_SET, $urandom, $urandom_range(0, 127), $urandom_range(0, 31)));
      end else begin
        // Noise: any opcode, any field bits.
        send(make_req(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom));
      end
    end
    in_valid <= 1'b0;

    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d transactions (%0d ignored), %0d replies checked, %0d cell reads",
             sent, sent - counted, tracker.replies_checked, tracker.reads);
    $display("line wraps %0d, scrolls %0d, mismatches %0d",
             tracker.wraps, tracker.scrolls, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer.sv
dv/tb_text_console_writer.sv
